// File: sv/prra_pkg.sv
// Package for the strict-priority round-robin arbiter: shared types and constants.
// No dependencies; every other file of the block imports it.
package prra_pkg;

    localparam int NUM_LEVELS       = 4;
    localparam int QUEUES_PER_LEVEL = 16;
    localparam int LEVEL_W          = 2;
    localparam int QUEUE_W          = 4;
    localparam int PORT_W           = 4;
    localparam int MASK_W           = 64;
    localparam int DEF_NUM_PORTS    = 16;

    typedef struct packed {
        logic [PORT_W-1:0] out_port;
        logic [MASK_W-1:0] eligible_mask;
    } req_t;

    typedef struct packed {
        logic               grant_valid;
        logic [LEVEL_W-1:0] grant_level;
        logic [QUEUE_W-1:0] grant_queue;
    } grant_t;

    typedef struct packed {
        logic               found;
        logic [QUEUE_W-1:0] queue;
    } lane_res_t;

endpackage

// File: sv/prra_lane.sv
// One priority-level lane: rotating priority encoder over the queues of one level.
// Depends on prra_pkg.
module prra_lane
    import prra_pkg::*;
(
    input  logic [QUEUES_PER_LEVEL-1:0] elig,
    input  logic [QUEUE_W-1:0]          ptr,
    output lane_res_t                   res
);

    // Search from the pointer upwards first; if nothing is there, wrap to the bottom.
    always_comb
    begin
        logic [QUEUES_PER_LEVEL-1:0] upper;
        logic [QUEUES_PER_LEVEL-1:0] src;
        logic [QUEUES_PER_LEVEL-1:0] onehot;
        upper  = elig & ~((QUEUES_PER_LEVEL'(1) << ptr) - QUEUES_PER_LEVEL'(1));
        src    = (|upper) ? upper : elig;
        onehot = src & (~src + QUEUES_PER_LEVEL'(1));
        res.found = |elig;
        res.queue = '0;
        for (int i = 0; i < QUEUES_PER_LEVEL; i++)
        begin
            if (onehot[i])
            begin
                res.queue = res.queue | QUEUE_W'(i);
            end
        end
    end

endmodule

// File: sv/prra_merge.sv
// Merging stage: picks the lowest-numbered level whose lane found a queue.
// Depends on prra_pkg.
module prra_merge
    import prra_pkg::*;
(
    input  lane_res_t [NUM_LEVELS-1:0] lanes,
    output grant_t                     grant
);

    always_comb
    begin
        grant = '0;
        // Walk from the lowest priority up so that level 0 is assigned last and wins.
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (lanes[l].found)
            begin
                grant.grant_valid = 1'b1;
                grant.grant_level = LEVEL_W'(l);
                grant.grant_queue = lanes[l].queue;
            end
        end
    end

endmodule

// File: sv/priority_round_robin_arbiter_unit.sv
// Top level of the strict-priority round-robin output arbiter.
// Depends on prra_pkg, prra_lane and prra_merge.
//
//  Channel   Direction  Handshake                Beat payload
//  -------   ---------  -----------------------  ----------------------------------
//  request   in         start high, busy low     req   (out_port, eligible_mask)
//  grant     out        done high for one cycle  grant (grant_valid, level, queue)
//
// A request beat is registered at the edge that accepts it. In the following
// cycle the four level lanes run their rotating priority encoders in parallel
// against the pointer row of the named port, the merging stage selects the
// highest-priority level with an eligible queue, and the winner's pointer is
// written back. The grant beat appears with done in the cycle after that, and one
// request can be accepted every cycle; busy is never raised. The pointer write lands
// before the next request reads the row.
// Reset clears all round-robin pointers to zero at once. The receiver cannot
// stall: each grant beat is shown for exactly one cycle.
module priority_round_robin_arbiter_unit
    import prra_pkg::*;
#(
    parameter int NUM_PORTS = DEF_NUM_PORTS
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  req_t   req,
    output logic   done,
    output grant_t grant
);

    localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // Request stage registers.
    logic              s1_vld_reg;
    logic              s1_vld_next;
    logic [PORT_W-1:0] port_reg;
    logic [MASK_W-1:0] mask_reg;

    // Result registers.
    logic   done_reg;
    logic   done_next;
    grant_t grant_reg;

    // Round-robin pointers: one row per port, holding one pointer for each level.
    logic [NUM_LEVELS-1:0][QUEUE_W-1:0] ptr_reg [NUM_PORTS];
    logic [QUEUE_W-1:0] ptr_next;

    logic                   accept;
    logic                   port_ok;
    logic [PORT_IDX_W-1:0]  port_idx;
    logic [MASK_W-1:0]      eff_mask;
    lane_res_t [NUM_LEVELS-1:0] lane_res;
    grant_t                 merged;

    // The block takes a request beat in every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign port_ok  = (32'(port_reg) < NUM_PORTS);
    assign port_idx = PORT_IDX_W'(port_reg);

    // A port outside the table sees nothing eligible, so no grant and no pointer move.
    assign eff_mask = port_ok ? mask_reg : '0;

    genvar g;
    generate
        for (g = 0; g < NUM_LEVELS; g++)
        begin : g_lane
            logic [QUEUE_W-1:0] lane_ptr;
            assign lane_ptr = port_ok ? ptr_reg[port_idx][g] : '0;

            prra_lane u_lane (
                .elig (eff_mask[g*QUEUES_PER_LEVEL +: QUEUES_PER_LEVEL]),
                .ptr  (lane_ptr),
                .res  (lane_res[g])
            );
        end
    endgenerate

    prra_merge u_merge (
        .lanes (lane_res),
        .grant (merged)
    );

    // Pointer moves to just past the winner, wrapping within the level.
    assign ptr_next = merged.grant_queue + QUEUE_W'(1);

    always_comb
    begin
        s1_vld_next = accept;
        done_next   = s1_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            port_reg <= req.out_port;
            mask_reg <= req.eligible_mask;
        end
        if (s1_vld_reg)
        begin
            grant_reg <= merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                ptr_reg[p] <= '0;
            end
        end
        else if (s1_vld_reg && merged.grant_valid)
        begin
            ptr_reg[port_idx][merged.grant_level] <= ptr_next;
        end
    end

    assign done  = done_reg;
    assign grant = grant_reg;

    // A grant beat always follows a valid request in the request stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_vld_reg))
        else $error("grant beat without a request in the stage before");

    // The merged winner must be a queue whose eligibility bit is set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && merged.grant_valid) |->
            eff_mask[32'(merged.grant_level) * QUEUES_PER_LEVEL + 32'(merged.grant_queue)])
        else $error("grant given to a queue that was not eligible");

    // A port outside the table never receives a grant.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !port_ok) |=> (done && !grant.grant_valid))
        else $error("grant issued for a port outside the table");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for priority_round_robin_arbiter_unit: directed and random request beats.
// Depends on prra_pkg and the arbiter RTL; holds its own model of the pointer table.
module testbench;
    import prra_pkg::*;

    // The block is built with its default port count.
    localparam int TB_PORTS      = DEF_NUM_PORTS;
    // The grant beat follows the request beat through the request stage and the result registers.
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS   = 10;

    // Shapes of eligibility mask that the random stimulus draws from.
    typedef enum int {
        MASK_EMPTY,
        MASK_FULL_RANDOM,
        MASK_ONE_LEVEL,
        MASK_FEW_BITS,
        MASK_SPARSE,
        MASK_ALL_ONES,
        MASK_LOW_PRIORITY_ONLY,
        MASK_KIND_COUNT
    } mask_kind_e;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    req_t   req;
    logic   done;
    grant_t grant;

    // Model state: one round-robin pointer per port and priority level.
    logic [QUEUE_W-1:0] rotate_ptr [TB_PORTS][NUM_LEVELS];

    // Grant beats that the model says the block still owes, oldest first.
    grant_t pending_grants [$];

    int mismatches;
    int requests_sent;
    int empty_rounds;
    int level_wins [NUM_LEVELS];

    priority_round_robin_arbiter_unit #(
        .NUM_PORTS (TB_PORTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .grant (grant)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Safety net: a correct run finishes far inside this time.
    initial
    begin
        #2_000_000;
        $display("Timeout waiting for the arbiter to finish.");
        $display("Mismatches found");
        $finish;
    end

    // Runs one allocation round on the model. Priority level 0 is searched first; within the
    // first level that has any eligible queue, the search starts at that level's pointer and
    // wraps round, and the pointer then moves to the queue just past the winner.
    function automatic grant_t arbitrate(input req_t r);
        grant_t             g;
        logic [QUEUE_W-1:0] q;
        g = '0;
        if (r.out_port >= TB_PORTS)
            return g;
        for (int lvl = 0; lvl < NUM_LEVELS; lvl++)
        begin
            for (int k = 0; k < QUEUES_PER_LEVEL; k++)
            begin
                q = QUEUE_W'(rotate_ptr[r.out_port][lvl] + k);
                if (r.eligible_mask[lvl * QUEUES_PER_LEVEL + q])
                begin
                    rotate_ptr[r.out_port][lvl] = q + 1'b1;
                    g.grant_valid = 1'b1;
                    g.grant_level = LEVEL_W'(lvl);
                    g.grant_queue = q;
                    return g;
                end
            end
        end
        return g;
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] m;
        mask_kind_e        kind;
        int                lvl;
        kind = mask_kind_e'($urandom_range(MASK_KIND_COUNT - 1));
        m    = '0;
        case (kind)
            MASK_EMPTY:
                m = '0;
            MASK_FULL_RANDOM:
                m = {$urandom, $urandom};
            MASK_ONE_LEVEL:
            begin
                lvl = $urandom_range(NUM_LEVELS - 1);
                m   = MASK_W'($urandom_range(16'hFFFF)) << (lvl * QUEUES_PER_LEVEL);
            end
            MASK_FEW_BITS:
                repeat ($urandom_range(1, 3))
                    m[$urandom_range(MASK_W - 1)] = 1'b1;
            MASK_SPARSE:
                m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            MASK_ALL_ONES:
                m = '1;
            default:
            begin
                // Nothing at the higher levels, so the lower levels get to win.
                lvl = $urandom_range(1, NUM_LEVELS - 1);
                m   = {$urandom, $urandom};
                m   = (m >> (lvl * QUEUES_PER_LEVEL)) << (lvl * QUEUES_PER_LEVEL);
            end
        endcase
        return m;
    endfunction

    // Ports are drawn mostly from a small set so that pointer rows get revisited often.
    function automatic logic [PORT_W-1:0] random_port();
        if ($urandom_range(1))
            return PORT_W'($urandom_range(3));
        return PORT_W'($urandom_range(TB_PORTS - 1));
    endfunction

    // Presents one request beat from a falling edge and holds it until the block takes it.
    // On return it is the falling edge after acceptance, with start still high, so that a
    // back-to-back beat never sees start dropped and raised in the same step.
    task automatic issue_request(input logic [PORT_W-1:0] port, input logic [MASK_W-1:0] mask);
        req_t   r;
        grant_t g;
        r.out_port      = port;
        r.eligible_mask = mask;
        start = 1'b1;
        req   = r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        g = arbitrate(r);
        pending_grants = {pending_grants, g};
        requests_sent++;
        if (!g.grant_valid)
            empty_rounds++;
        else
            level_wins[g.grant_level]++;
        @(negedge clk);
    endtask

    // Leaves the sender idle for a random number of cycles: each cycle idles with
    // probability pct in a hundred. The request bus carries junk while start is low.
    task automatic sender_gap(input int pct);
        int n;
        n = 0;
        while (n < 24 && $urandom_range(99) < pct)
            n++;
        if (n > 0)
        begin
            start             = 1'b0;
            req.out_port      = PORT_W'($urandom);
            req.eligible_mask = {$urandom, $urandom};
            repeat (n) @(negedge clk);
        end
    endtask

    // Stops sending until every owed grant beat has arrived, then lets the pipe settle.
    task automatic drain_grants();
        start = 1'b0;
        while (pending_grants.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Hand-picked rounds: empty and full masks, the corner bits, pointer wrap-round,
    // a single queue sitting just before the pointer, and strict priority between levels.
    task automatic test_directed();
        issue_request(4'd0,  64'h0);
        issue_request(4'd0,  '1);
        issue_request(4'd0,  '1);
        issue_request(4'd0,  64'h8000_0000_0000_0000);
        issue_request(4'd15, 64'h0000_0000_0000_0001);
        issue_request(4'd15, 64'h8000_0000_0000_0000);
        issue_request(4'd15, 64'h8000_0000_0000_0000);
        // Queue 15 wins, so the pointer wraps back to zero.
        issue_request(4'd1,  64'h0000_0000_0000_8000);
        issue_request(4'd1,  64'h0000_0000_0000_8001);
        // Two queues at level 1 take turns.
        issue_request(4'd2,  64'h0000_0000_0208_0000);
        issue_request(4'd2,  64'h0000_0000_0208_0000);
        issue_request(4'd2,  64'h0000_0000_0208_0000);
        // After queue 10 wins, queue 2 lies behind the pointer and must wait for queue 12.
        issue_request(4'd3,  64'h0000_0000_0000_0400);
        issue_request(4'd3,  64'h0000_0000_0000_1004);
        issue_request(4'd3,  64'h0000_0000_0000_0004);
        // Level 0 beats everything below it, whatever the pointers say.
        issue_request(4'd3,  64'hFFFF_FFFF_0000_0020);
        issue_request(4'd4,  64'hFFFF_0000_0000_0000);
        issue_request(4'd4,  64'hFFFF_0000_0000_0000);
        issue_request(4'd15, 64'hAAAA_AAAA_AAAA_AAAA);
        issue_request(4'd15, 64'h5555_5555_5555_5555);
        issue_request(4'd8,  64'h0000_FFFF_0000_0000);
        issue_request(4'd8,  64'h0000_0000_0000_0000);
        // The sender waits here until every grant has come back.
        drain_grants();
    endtask

    // Well-formed rotation runs: one port sees the same competing set for a while, so the
    // pointer must walk through every contender in turn. Some rounds add extra queues, also
    // at lower-priority levels, which must never win while the upper set is non-empty.
    task automatic test_rotation(input int runs, input int pct);
        logic [PORT_W-1:0] port;
        logic [MASK_W-1:0] mask;
        logic [MASK_W-1:0] noise;
        int                lvl;
        for (int i = 0; i < runs; i++)
        begin
            port  = random_port();
            lvl   = $urandom_range(NUM_LEVELS - 1);
            mask  = MASK_W'($urandom_range(1, 16'hFFFF)) << (lvl * QUEUES_PER_LEVEL);
            noise = {$urandom, $urandom};
            repeat ($urandom_range(4, 18))
            begin
                if ($urandom_range(3) == 0)
                    issue_request(port, mask | ((noise >> 1) & ~(mask - 1'b1)));
                else
                    issue_request(port, mask);
                sender_gap(pct);
            end
            // An occasional stray round on some other port between runs.
            if ($urandom_range(2) == 0)
            begin
                issue_request(random_port(), random_mask());
                sender_gap(pct);
            end
        end
        drain_grants();
    endtask

    task automatic test_random_traffic(input int count, input int pct);
        repeat (count)
        begin
            issue_request(random_port(), random_mask());
            sender_gap(pct);
        end
        drain_grants();
    endtask

    // Each grant beat is shown for one cycle only, so it is taken at the rising edge that
    // ends that cycle and compared with the oldest grant the model predicted.
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: grant beat with none expected: valid=%b level=%0d queue=%0d",
                             $realtime, grant.grant_valid, grant.grant_level,
                             grant.grant_queue);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (done !== 1'b1
                    || grant.grant_valid !== want.grant_valid
                    || grant.grant_level !== want.grant_level
                    || grant.grant_queue !== want.grant_queue)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: grant mismatch: expected valid=%b level=%0d queue=%0d,",
                                  " got valid=%b level=%0d queue=%0d (done=%b)"},
                                 $realtime, want.grant_valid, want.grant_level,
                                 want.grant_queue, grant.grant_valid, grant.grant_level,
                                 grant.grant_queue, done);
                end
            end
        end
    end

    initial
    begin
        mismatches    = 0;
        requests_sent = 0;
        empty_rounds  = 0;
        for (int l = 0; l < NUM_LEVELS; l++)
            level_wins[l] = 0;
        for (int p = 0; p < TB_PORTS; p++)
            for (int l = 0; l < NUM_LEVELS; l++)
                rotate_ptr[p][l] = '0;
        start = 1'b0;
        req   = '0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        // Back-to-back beats, then a sender that is mostly idle, then one that idles less.
        test_random_traffic(180, 0);
        test_rotation(12, 0);
        test_random_traffic(180, 65);
        test_rotation(8, 65);
        test_random_traffic(180, 35);
        test_rotation(8, 35);

        if (pending_grants.size() != 0)
        begin
            mismatches += pending_grants.size();
            $display("%0d grant beats never arrived.", pending_grants.size());
        end
        $display("Ran %0d allocation rounds, %0d of them with nothing eligible.",
                 requests_sent, empty_rounds);
        $display("Grants won at priority levels 0 to 3: %0d, %0d, %0d, %0d.",
                 level_wins[0], level_wins[1], level_wins[2], level_wins[3]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
